// ----- rtl/core/blocked_bound_search_assert.svh -----
// assertion macros for the blocked bound search checker
// expects signals named clock and reset in the scope of use
`ifndef BLOCKED_BOUND_SEARCH_ASSERT_SVH
`define BLOCKED_BOUND_SEARCH_ASSERT_SVH

// property checked only outside reset
`define BBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that also covers the reset cycles
`define BBS_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/bbs_pkg.sv -----
// shared types, defaults and float compare helpers for the blocked bound search
// no dependencies
`default_nettype none

package bbs_pkg;

   localparam int MAX_SCANS_DEF  = 4096;
   localparam int MAX_BLOCKS_DEF = 256;
   localparam int DIMS_DEF       = 4;

   // item actions
   typedef enum logic [1:0] {
      ACT_STORE = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_LOWER = 2'd2,
      ACT_UPPER = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [1:0]  dim;
      logic [63:0] value;
      logic        end_of_scan;
      logic        end_of_block;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  block_index;
      logic [11:0] scan_index;
   } rsp_type;

   // float64 nan test
   function automatic logic fp_is_nan(logic [63:0] a);
      return (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
   endfunction

   // ieee a < b, false on any nan
   function automatic logic fp_lt(logic [63:0] a, logic [63:0] b);
      logic res;
      res = 1'b0;
      if (!fp_is_nan(a) && !fp_is_nan(b) &&
          !((a[62:0] == 63'd0) && (b[62:0] == 63'd0))) begin
         if (a[63] != b[63]) begin
            res = a[63];
         end else if (!a[63]) begin
            res = a[62:0] < b[62:0];
         end else begin
            res = a[62:0] > b[62:0];
         end
      end
      return res;
   endfunction

   // ieee a <= b, false on any nan
   function automatic logic fp_le(logic [63:0] a, logic [63:0] b);
      logic eq;
      eq = !fp_is_nan(a) && !fp_is_nan(b) &&
           ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
      return eq || fp_lt(a, b);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bbs_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module bbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/blocked_bound_search.sv -----
// channel  ports                         handshake
// request  start, busy, req_item         taken when start high and busy low
// result   rsp_strobe, rsp_item          valid for one cycle, always taken
//
// store and clear items finish at the accept; busy stays low.
// a query holds busy while it probes blocks (block midpoint, block end read, previous end read, base,
// first and last sample) and steps the in-block search (midpoint, compare), then finishes on a hit,
// a miss, or a read of the block before the key; the steps are set by the single read port of the
// sample memory and of the block end memory. dim out of range answers in the cycle after the accept.
// busy covers the result cycle. reset clears the counts and the state; memory contents are not cleared.
// depends on bbs_pkg and bbs_ram
`default_nettype none

module blocked_bound_search #(
   parameter int MAX_SCANS  = bbs_pkg::MAX_SCANS_DEF,
   parameter int MAX_BLOCKS = bbs_pkg::MAX_BLOCKS_DEF,
   parameter int DIMS       = bbs_pkg::DIMS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bbs_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output bbs_pkg::rsp_type      rsp_item
);

   localparam int FILL_W = $clog2(MAX_SCANS + 1);
   localparam int SI_W   = FILL_W + 1;
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
   localparam int BI_W   = CNT_W + 1;
   localparam int BA_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int SDEPTH = MAX_SCANS * DIMS;
   localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_BMID  = 11'b00000000010,
      ST_BRDE  = 11'b00000000100,
      ST_BRDS  = 11'b00000001000,
      ST_BBASE = 11'b00000010000,
      ST_FIRST = 11'b00000100000,
      ST_LAST  = 11'b00001000000,
      ST_IMID  = 11'b00010000000,
      ST_ICMP  = 11'b00100000000,
      ST_FIN   = 11'b01000000000,
      ST_DONE  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic upper_ff, upper_in;
   logic fin_ff, fin_in;
   logic [1:0] col_ff, col_in;
   logic [63:0] key_ff, key_in;
   logic signed [BI_W-1:0] blo_ff, blo_in, bhi_ff, bhi_in;
   logic [BA_W-1:0] bmid_ff, bmid_in;
   logic [FILL_W-1:0] end_ff, end_in, base_ff, base_in;
   logic signed [SI_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [63:0] first_ff, first_in;
   bbs_pkg::rsp_type rsp_ff, rsp_in;

   // memory ports
   logic s_wr_en;
   logic [SA_W-1:0] s_wr_addr, s_rd_addr;
   logic [63:0] s_rd_data;
   logic e_wr_en;
   logic [BA_W-1:0] e_wr_addr, e_rd_addr;
   logic [FILL_W-1:0] e_wr_data, e_rd_data;

   // scratch
   logic [FILL_W-1:0] start_w;
   logic signed [BI_W:0] bsum_w;
   logic signed [SI_W:0] isum_w;
   logic [FILL_W-1:0] fill_inc_w;
   logic before_w, after_w, take_w;

   function automatic logic [SA_W-1:0] saddr(logic [FILL_W-1:0] scan, logic [1:0] col);
      return SA_W'(SA_W'(scan) * SA_W'(DIMS) + SA_W'(col));
   endfunction

   bbs_ram #(.WIDTH(64), .DEPTH(SDEPTH), .AW(SA_W)) u_samples (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (s_wr_addr),
      .wr_data (req_item.value),
      .rd_addr (s_rd_addr),
      .rd_data (s_rd_data)
   );

   bbs_ram #(.WIDTH(FILL_W), .DEPTH(MAX_BLOCKS), .AW(BA_W)) u_block_ends (
      .clock   (clock),
      .wr_en   (e_wr_en),
      .wr_addr (e_wr_addr),
      .wr_data (e_wr_data),
      .rd_addr (e_rd_addr),
      .rd_data (e_rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign rsp_item   = rsp_ff;

   // start of the probed block comes from the previous block end
   assign start_w    = (bmid_ff == BA_W'(0)) ? FILL_W'(0) : e_rd_data;
   assign bsum_w     = (BI_W + 1)'(blo_ff) + (BI_W + 1)'(bhi_ff);
   assign isum_w     = (SI_W + 1)'(lo_ff) + (SI_W + 1)'(hi_ff);
   assign fill_inc_w = fill_ff + FILL_W'(1);

   // end-point tests of the probed block, last sample on the read port
   always_comb begin
      if (upper_ff) begin
         before_w = bbs_pkg::fp_lt(key_ff, first_ff);
         after_w  = bbs_pkg::fp_le(s_rd_data, key_ff);
         take_w   = bbs_pkg::fp_lt(key_ff, s_rd_data);
      end else begin
         before_w = bbs_pkg::fp_le(key_ff, first_ff);
         after_w  = bbs_pkg::fp_lt(s_rd_data, key_ff);
         take_w   = !bbs_pkg::fp_lt(s_rd_data, key_ff);
      end
   end

   // read addresses
   always_comb begin
      e_rd_addr = bmid_ff;
      if (state_ff == ST_BRDS) begin
         e_rd_addr = bmid_ff - BA_W'(1);
      end
      case (state_ff)
         ST_BBASE: s_rd_addr = saddr(start_w, col_ff);
         ST_FIRST: s_rd_addr = saddr(end_ff - FILL_W'(1), col_ff);
         ST_IMID:  s_rd_addr = saddr(base_ff + FILL_W'(isum_w >>> 1), col_ff);
         default:  s_rd_addr = saddr(base_ff, col_ff);
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      upper_in  = upper_ff;
      fin_in    = fin_ff;
      col_in    = col_ff;
      key_in    = key_ff;
      blo_in    = blo_ff;
      bhi_in    = bhi_ff;
      bmid_in   = bmid_ff;
      end_in    = end_ff;
      base_in   = base_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      first_in  = first_ff;
      rsp_in    = rsp_ff;
      s_wr_en   = 1'b0;
      s_wr_addr = saddr(fill_ff, req_item.dim);
      e_wr_en   = 1'b0;
      e_wr_addr = BA_W'(count_ff);
      e_wr_data = fill_inc_w;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_item.action)
                  bbs_pkg::ACT_STORE: begin
                     if ((32'(req_item.dim) < DIMS) && (32'(fill_ff) < MAX_SCANS) &&
                         (32'(count_ff) < MAX_BLOCKS)) begin
                        s_wr_en = 1'b1;
                        if (req_item.end_of_scan) begin
                           fill_in = fill_inc_w;
                           if (req_item.end_of_block) begin
                              e_wr_en  = 1'b1;
                              count_in = count_ff + CNT_W'(1);
                           end
                        end
                     end
                  end
                  bbs_pkg::ACT_CLEAR: begin
                     fill_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                     upper_in = (req_item.action == bbs_pkg::ACT_UPPER);
                     col_in   = req_item.dim;
                     key_in   = req_item.value;
                     fin_in   = 1'b0;
                     blo_in   = '0;
                     bhi_in   = $signed(BI_W'(count_ff)) - $signed(BI_W'(1));
                     rsp_in   = '0;
                     if (32'(req_item.dim) < DIMS) begin
                        state_in = ST_BMID;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         // next block probe or finish
         ST_BMID: begin
            if (blo_ff > bhi_ff) begin
               state_in = ST_FIN;
            end else begin
               bmid_in  = BA_W'(bsum_w >>> 1);
               state_in = ST_BRDE;
            end
         end
         ST_BRDE: state_in = ST_BRDS;
         ST_BRDS: begin
            end_in   = e_rd_data;
            state_in = ST_BBASE;
         end
         ST_BBASE: begin
            base_in = start_w;
            hi_in   = $signed(SI_W'(end_ff)) - $signed(SI_W'(start_w)) - $signed(SI_W'(1));
            lo_in   = '0;
            if (fin_ff) begin
               rsp_in.found       = 1'b1;
               rsp_in.block_index = 8'(bmid_ff);
               rsp_in.scan_index  = 12'(end_ff - start_w - FILL_W'(1));
               state_in           = ST_DONE;
            end else begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            first_in = s_rd_data;
            state_in = ST_LAST;
         end
         // end-point decision for the probed block
         ST_LAST: begin
            if (before_w) begin
               bhi_in   = $signed(BI_W'(bmid_ff)) - $signed(BI_W'(1));
               state_in = ST_BMID;
            end else if (after_w) begin
               blo_in   = $signed(BI_W'(bmid_ff)) + $signed(BI_W'(1));
               state_in = ST_BMID;
            end else begin
               state_in = ST_IMID;
            end
         end
         // in-block floor midpoint search
         ST_IMID: begin
            if (lo_ff > hi_ff) begin
               rsp_in.found       = 1'b1;
               rsp_in.block_index = 8'(bmid_ff);
               rsp_in.scan_index  = upper_ff ? 12'(hi_ff) : 12'(lo_ff);
               state_in           = ST_DONE;
            end else begin
               mid_in   = SI_W'(isum_w >>> 1);
               state_in = ST_ICMP;
            end
         end
         ST_ICMP: begin
            if (take_w) begin
               hi_in = mid_ff - $signed(SI_W'(1));
            end else begin
               lo_in = mid_ff + $signed(SI_W'(1));
            end
            state_in = ST_IMID;
         end
         // no block holds the position: neighbor block or not found
         ST_FIN: begin
            if (upper_ff) begin
               if (bhi_ff >= $signed(BI_W'(0))) begin
                  fin_in   = 1'b1;
                  bmid_in  = BA_W'(bhi_ff);
                  state_in = ST_BRDE;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               if (blo_ff < $signed(BI_W'(count_ff))) begin
                  rsp_in.found       = 1'b1;
                  rsp_in.block_index = 8'(blo_ff);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   // search registers
   always_ff @(posedge clock) begin
      upper_ff <= upper_in;
      fin_ff   <= fin_in;
      col_ff   <= col_in;
      key_ff   <= key_in;
      blo_ff   <= blo_in;
      bhi_ff   <= bhi_in;
      bmid_ff  <= bmid_in;
      end_ff   <= end_in;
      base_ff  <= base_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      first_ff <= first_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/bbs_checker.sv -----
// port level checks for the blocked bound search, bound to the top level
// depends on bbs_pkg and blocked_bound_search_assert.svh
`default_nettype none

`include "blocked_bound_search_assert.svh"

module bbs_port_assert (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire bbs_pkg::req_type req_item,
   input wire logic             rsp_strobe,
   input wire bbs_pkg::rsp_type rsp_item
);

   // result only shows while the query holds the block
   `BBS_ASSERT(a_strobe_busy, rsp_strobe |-> busy, "result outside busy")
   // one result per query
   `BBS_ASSERT(a_strobe_single, rsp_strobe |=> !rsp_strobe, "result longer than one cycle")
   // not found clears the position
   `BBS_ASSERT(a_miss_zero, rsp_strobe && !rsp_item.found |-> rsp_item == '0, "miss with position")
   // store and clear finish at once
   `BBS_ASSERT(a_store_fast, start && !busy && (req_item.action == bbs_pkg::ACT_STORE || req_item.action == bbs_pkg::ACT_CLEAR) |=> !busy && !rsp_strobe, "store held busy")
   // reset leaves the block idle
   `BBS_ASSERT_RST(a_reset_idle, reset |=> !busy && !rsp_strobe, "busy after reset")

endmodule

bind blocked_bound_search bbs_port_assert u_bbs_port_assert (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire
